### design/gwr_pkg.sv
// Shared types and constants for the greedy word-wrap row generator.
package gwr_pkg;

  localparam int unsigned CHAR_W = 21;
  localparam int unsigned OUT_W  = 24;
  localparam int unsigned WRAP_W = 10;

  localparam logic [CHAR_W-1:0] TAB_CODE     = CHAR_W'(9);
  localparam logic [CHAR_W-1:0] NEWLINE_CODE = CHAR_W'(10);
  localparam logic [CHAR_W-1:0] SPACE_CODE   = CHAR_W'(32);

  localparam int unsigned       TAB_COLS     = 4;
  localparam logic [WRAP_W-1:0] WRAP_DEFAULT = WRAP_W'(80);

  typedef enum logic {
    OP_CHAR = 1'b0,
    OP_END  = 1'b1
  } gwr_op_t;

  typedef struct packed {
    gwr_op_t           operation;
    logic [CHAR_W-1:0] char_code;
  } gwr_item_t;

  typedef struct packed {
    logic [OUT_W-1:0] row_origin;
    logic [OUT_W-1:0] line_number;
    logic             final_row;
  } gwr_row_t;

  // Handshake between the row engine and the result register.
  typedef struct packed {
    logic emit;
    logic consume;
  } gwr_ctl_t;

endpackage

### design/gwr_in_stage.sv
// Input register holding one character request ahead of the row engine.
module gwr_in_stage
  import gwr_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  input  gwr_item_t in_item,
  input  logic      consume,
  output logic      item_valid,
  output gwr_item_t item
);

  logic item_valid_next;

  assign in_ready = !item_valid || consume;

  always_comb begin
    item_valid_next = item_valid;
    if (in_valid && in_ready) begin
      item_valid_next = 1'b1;
    end else if (consume) begin
      item_valid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else begin
      item_valid <= item_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item <= in_item;
    end
  end

  // A held request that is not consumed must survive to the next cycle.
  a_hold_pending: assert property (@(posedge clk) disable iff (rst)
    item_valid && !consume |=> item_valid)
    else $error("pending request dropped");

  // A request only leaves the register when it is actually there.
  a_consume_valid: assert property (@(posedge clk) disable iff (rst)
    consume |-> item_valid)
    else $error("consume without request");

endmodule

### design/gwr_row_engine.sv
// Row engine: wrap state registers and the per-character update logic.
module gwr_row_engine
  import gwr_pkg::*;
#(
  parameter int unsigned POS_BITS = 24,
  parameter int unsigned COL_BITS = 11
) (
  input  logic              clk,
  input  logic              rst,
  input  logic [WRAP_W-1:0] wrap_width,
  input  logic              item_valid,
  input  gwr_item_t         item,
  input  logic              out_free,
  output gwr_ctl_t          ctl,
  output gwr_row_t          row
);

  localparam int unsigned CMP_W = (COL_BITS > WRAP_W) ? COL_BITS : WRAP_W;

  logic [POS_BITS-1:0] char_position, char_position_next;
  logic [POS_BITS-1:0] current_line, current_line_next;
  logic [POS_BITS-1:0] current_row_start, current_row_start_next;
  logic [COL_BITS-1:0] column_count, column_count_next;
  logic                break_valid, break_valid_next;
  logic [POS_BITS-1:0] break_position, break_position_next;
  logic [COL_BITS-1:0] width_since_break, width_since_break_next;

  logic [POS_BITS-1:0] pos_after;
  logic [WRAP_W-1:0]   limit;
  logic [COL_BITS-1:0] cw;
  logic [COL_BITS-1:0] base;
  logic [COL_BITS-1:0] col_sum;
  logic [COL_BITS-1:0] base_plus;
  logic                is_tab, is_break, is_newline;
  logic                brk_valid_cand;
  logic [POS_BITS-1:0] brk_pos_cand;
  logic                overflow;
  logic                brk_take;
  logic                emit;
  logic                fire;
  logic [POS_BITS+OUT_W-1:0] start_ext, line_ext;

  function automatic logic [POS_BITS-1:0] pos_inc(input logic [POS_BITS-1:0] a);
    return (&a) ? a : a + 1'b1;
  endfunction

  function automatic logic [COL_BITS-1:0] col_add(input logic [COL_BITS-1:0] a,
                                                  input logic [COL_BITS-1:0] b);
    logic [COL_BITS:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[COL_BITS] ? {COL_BITS{1'b1}} : s[COL_BITS-1:0];
  endfunction

  assign is_tab     = (item.char_code == TAB_CODE);
  assign is_newline = (item.char_code == NEWLINE_CODE);
  assign is_break   = is_tab || (item.char_code == SPACE_CODE);
  assign cw         = is_tab ? COL_BITS'(TAB_COLS) : COL_BITS'(1);
  assign limit      = (wrap_width == '0) ? WRAP_DEFAULT : wrap_width;
  assign pos_after  = pos_inc(char_position);
  assign base       = is_break ? '0 : width_since_break;
  assign col_sum    = col_add(column_count, cw);
  assign base_plus  = col_add(base, cw);

  assign brk_valid_cand = is_break || break_valid;
  assign brk_pos_cand   = is_break ? pos_after : break_position;
  assign overflow       = CMP_W'(col_sum) > CMP_W'(limit);
  assign brk_take       = brk_valid_cand && (brk_pos_cand > current_row_start);

  // A result comes out on end of text, on newline and on overflow.
  assign emit = (item.operation == OP_END) || is_newline || overflow;
  assign fire = item_valid && (!emit || out_free);

  assign ctl.emit    = item_valid && emit;
  assign ctl.consume = fire;

  assign start_ext       = {{OUT_W{1'b0}}, current_row_start};
  assign line_ext        = {{OUT_W{1'b0}}, current_line};
  assign row.row_origin  = start_ext[OUT_W-1:0];
  assign row.line_number = line_ext[OUT_W-1:0];
  assign row.final_row   = (item.operation == OP_END);

  always_comb begin
    char_position_next     = char_position;
    current_line_next      = current_line;
    current_row_start_next = current_row_start;
    column_count_next      = column_count;
    break_valid_next       = break_valid;
    break_position_next    = break_position;
    width_since_break_next = width_since_break;
    priority if (item.operation == OP_END) begin
      char_position_next     = '0;
      current_line_next      = '0;
      current_row_start_next = '0;
      column_count_next      = '0;
      break_valid_next       = 1'b0;
      break_position_next    = '0;
      width_since_break_next = '0;
    end else if (is_newline) begin
      char_position_next     = pos_after;
      current_line_next      = pos_inc(current_line);
      current_row_start_next = pos_after;
      column_count_next      = '0;
      break_valid_next       = 1'b0;
      break_position_next    = '0;
      width_since_break_next = '0;
    end else if (overflow) begin
      char_position_next     = pos_after;
      break_position_next    = brk_pos_cand;
      break_valid_next       = 1'b0;
      width_since_break_next = '0;
      if (brk_take) begin
        current_row_start_next = brk_pos_cand;
        column_count_next      = base_plus;
      end else begin
        current_row_start_next = char_position;
        column_count_next      = cw;
      end
    end else begin
      char_position_next     = pos_after;
      column_count_next      = col_sum;
      break_valid_next       = brk_valid_cand;
      break_position_next    = brk_pos_cand;
      width_since_break_next = is_break ? '0 : base_plus;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      char_position     <= '0;
      current_line      <= '0;
      current_row_start <= '0;
      column_count      <= '0;
      break_valid       <= 1'b0;
      break_position    <= '0;
      width_since_break <= '0;
    end else if (fire) begin
      char_position     <= char_position_next;
      current_line      <= current_line_next;
      current_row_start <= current_row_start_next;
      column_count      <= column_count_next;
      break_valid       <= break_valid_next;
      break_position    <= break_position_next;
      width_since_break <= width_since_break_next;
    end
  end

  // End of text returns every piece of text state to zero.
  a_end_clears: assert property (@(posedge clk) disable iff (rst)
    fire && item.operation == OP_END |=>
      char_position == '0 && current_line == '0 && column_count == '0 && !break_valid)
    else $error("end of text left state behind");

  // A newline opens an empty row at the following position.
  a_newline_row: assert property (@(posedge clk) disable iff (rst)
    fire && item.operation == OP_CHAR && is_newline |=>
      column_count == '0 && current_row_start == char_position)
    else $error("newline row not opened correctly");

  // Any wrap drops the break point.
  a_wrap_drops_break: assert property (@(posedge clk) disable iff (rst)
    fire && item.operation == OP_CHAR && !is_newline && overflow |=>
      !break_valid && width_since_break == '0)
    else $error("break point survived a wrap");

  // The state never moves while the held request is stalled.
  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    !fire |=> $stable(char_position) && $stable(current_row_start))
    else $error("state moved without a consumed request");

endmodule

### design/gwr_out_stage.sv
// Result register between the row engine and the output channel.
module gwr_out_stage
  import gwr_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  gwr_ctl_t ctl,
  input  gwr_row_t row_in,
  output logic     out_free,
  output logic     out_valid,
  input  logic     out_ready,
  output gwr_row_t row
);

  logic load;
  logic out_valid_next;

  assign out_free = !out_valid || out_ready;
  assign load     = ctl.emit && ctl.consume;

  always_comb begin
    out_valid_next = out_valid;
    if (load) begin
      out_valid_next = 1'b1;
    end else if (out_ready) begin
      out_valid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      row <= row_in;
    end
  end

  // A new row may only be loaded into a free slot.
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    load |-> out_free)
    else $error("result overwritten before it was taken");

  // A row loaded into the register is offered in the next cycle.
  a_load_shows: assert property (@(posedge clk) disable iff (rst)
    load |=> out_valid)
    else $error("loaded row not offered");

endmodule

### design/greedy_word_wrap_rows.sv
// Top level of the greedy word-wrap row generator.
//
//  channel | direction | handshake             | payload
//  --------+-----------+-----------------------+-------------------------------------
//  in      | input     | in_valid / in_ready   | operation, char_code
//  out     | output    | out_valid / out_ready | row_origin, line_number, final_row
//  cfg     | input     | cfg_wr_en (no wait)   | cfg_wr_data -> wrap_width
//
// One character request is taken per cycle while no stalled result holds the
// engine; the engine updates its wrap state from the input register, and a row
// is offered only after it has been loaded into the result register.
// rst is synchronous: it empties both registers, clears the wrap state and
// sets wrap_width to 80. A stalled result holds the engine only for requests
// that produce a row; requests that produce nothing keep flowing.
module greedy_word_wrap_rows
  import gwr_pkg::*;
#(
  parameter int unsigned POS_BITS = 24,
  parameter int unsigned COL_BITS = 11
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic              operation,
  input  logic [CHAR_W-1:0] char_code,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [OUT_W-1:0]  row_origin,
  output logic [OUT_W-1:0]  line_number,
  output logic              final_row,
  input  logic              cfg_wr_en,
  input  logic [WRAP_W-1:0] cfg_wr_data
);

  logic [WRAP_W-1:0] wrap_width;
  gwr_item_t         in_item;
  gwr_item_t         item;
  logic              item_valid;
  gwr_ctl_t          ctl;
  gwr_row_t          eng_row;
  gwr_row_t          out_row;
  logic              out_free;

  // Wrap width register; zero is mapped to the default in the engine.
  always_ff @(posedge clk) begin
    if (rst) begin
      wrap_width <= WRAP_DEFAULT;
    end else if (cfg_wr_en) begin
      wrap_width <= cfg_wr_data;
    end
  end

  assign in_item.operation = gwr_op_t'(operation);
  assign in_item.char_code = char_code;

  // Hold the incoming request until the engine consumes it.
  gwr_in_stage u_in (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_item    (in_item),
    .consume    (ctl.consume),
    .item_valid (item_valid),
    .item       (item)
  );

  // Advance the wrap state and decide whether a row is emitted.
  gwr_row_engine #(
    .POS_BITS (POS_BITS),
    .COL_BITS (COL_BITS)
  ) u_engine (
    .clk        (clk),
    .rst        (rst),
    .wrap_width (wrap_width),
    .item_valid (item_valid),
    .item       (item),
    .out_free   (out_free),
    .ctl        (ctl),
    .row        (eng_row)
  );

  // Register the emitted row until the consumer takes it.
  gwr_out_stage u_out (
    .clk       (clk),
    .rst       (rst),
    .ctl       (ctl),
    .row_in    (eng_row),
    .out_free  (out_free),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .row       (out_row)
  );

  assign row_origin  = out_row.row_origin;
  assign line_number = out_row.line_number;
  assign final_row   = out_row.final_row;

  // Every accepted request reaches the input register.
  a_accept_lands: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> item_valid)
    else $error("accepted request not registered");

  // A configuration write lands in the wrap width register.
  a_cfg_write: assert property (@(posedge clk) disable iff (rst)
    cfg_wr_en |=> wrap_width == $past(cfg_wr_data))
    else $error("wrap width write lost");

endmodule
